FILE: hw/rtl/bta_pkg.sv
// Shared constants, types and a helper function of the buddy tree allocator.
package bta_pkg;

  localparam int unsigned TREE_ORDER  = 10;
  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned REQ_W       = 20;
  localparam int unsigned NODE_W      = TREE_ORDER + 1;
  localparam int unsigned NODE_COUNT  = (2 ** NODE_W) - 1;
  localparam int unsigned OFF_W       = TREE_ORDER;
  localparam int unsigned LVL_W       = $clog2(TREE_ORDER + 1);
  localparam int unsigned VAL_W       = $clog2(TREE_ORDER + 2) + 1;
  localparam int unsigned WANT_W      = $clog2(REQ_W + 1);

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FIT    = 2'd1,
    STS_ZERO      = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } status_e;

  typedef struct packed {
    logic    clr_step;
    logic    latch;
    logic    fetch;
    logic    init_desc;
    logic    desc_step;
    logic    mark;
    logic    free_mark;
    logic    up_step;
    logic    load_res;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic zero_size;
    logic no_fit;
    logic want_top;
    logic desc_last;
    logic bad_free;
    logic handle_root;
    logic at_root;
    logic up_last;
  } sts_t;

  // level of a heap node: TREE_ORDER minus its depth
  function automatic logic [LVL_W-1:0] node_level(logic [NODE_W-1:0] n);
    logic [NODE_W:0] v;
    int unsigned     d;
    v = {1'b0, n} + {{NODE_W{1'b0}}, 1'b1};
    d = 0;
    for (int unsigned i = 0; i <= NODE_W; i++) begin
      if (v[i]) begin
        d = i;
      end
    end
    return LVL_W'(TREE_ORDER - d);
  endfunction

endpackage

FILE: hw/rtl/bta_ifs.sv
// Request and response channel interfaces of the buddy tree allocator.
interface bta_req_if;
  import bta_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [REQ_W-1:0] request_bytes;
  logic [NODE_W-1:0] node_handle;

  modport source (output valid, action, request_bytes, node_handle, input ready);
  modport sink   (input valid, action, request_bytes, node_handle, output ready);
endinterface

interface bta_rsp_if;
  import bta_pkg::*;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [NODE_W-1:0] granted_node;
  logic [OFF_W-1:0]  block_offset;
  logic [LVL_W-1:0]  granted_order;

  modport source (output valid, status, granted_node, block_offset, granted_order,
                  input ready);
  modport sink   (input valid, status, granted_node, block_offset, granted_order,
                  output ready);
endinterface

FILE: hw/rtl/bta_dp.sv
// Datapath: node order memory, descent and merge logic, result registers.
module bta_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bta_pkg::cmd_t            cmd_i,
  output bta_pkg::sts_t            sts_o,
  input  logic                     action_i,
  input  logic [bta_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [bta_pkg::NODE_W-1:0] node_handle_i,
  output bta_pkg::status_e         status_o,
  output logic [bta_pkg::NODE_W-1:0] granted_node_o,
  output logic [bta_pkg::OFF_W-1:0]  block_offset_o,
  output logic [bta_pkg::LVL_W-1:0]  granted_order_o
);
  import bta_pkg::*;

  localparam int unsigned MEM_DEPTH = 2 ** NODE_W;

  logic signed [VAL_W-1:0] mem [MEM_DEPTH];
  logic signed [VAL_W-1:0] rda_q, rdb_q;

  logic              action_q;
  logic [REQ_W-1:0]  bytes_q;
  logic [NODE_W-1:0] handle_q;
  logic [WANT_W-1:0] want_q;
  logic [LVL_W-1:0]  hlvl_q;
  logic [NODE_W-1:0] n_q, u_q, clr_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [OFF_W-1:0]  off_q;
  logic signed [VAL_W-1:0] val_q;

  status_e           res_status_q;
  logic [NODE_W-1:0] res_node_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [LVL_W-1:0]  res_ord_q;

  logic              we;
  logic [NODE_W-1:0] waddr, raddr_a, raddr_b;
  logic signed [VAL_W-1:0] wdata;

  logic [REQ_W-1:0]  units;
  logic [WANT_W-1:0] want_d;
  logic signed [VAL_W-1:0] want_v, lvl_v, pv, alloc_mark, free_mark_v;
  logic              go_right;
  logic [NODE_W-1:0] child_l, child, next_l, next_r, par_u, sib_n, sib_h, sib_p;

  function automatic logic [NODE_W-1:0] sib_of(logic [NODE_W-1:0] x);
    return x[0] ? x + NODE_W'(1) : x - NODE_W'(1);
  endfunction

  function automatic logic [NODE_W-1:0] par_of(logic [NODE_W-1:0] x);
    return (x - NODE_W'(1)) >> 1;
  endfunction

  // size in minimum blocks minus one, order is its bit length
  always_comb begin
    units  = (bytes_q - REQ_W'(1)) >> BLOCK_SHIFT;
    want_d = '0;
    for (int unsigned i = 0; i < REQ_W; i++) begin
      if (units[i]) begin
        want_d = WANT_W'(i + 1);
      end
    end
  end

  assign want_v      = VAL_W'(want_q);
  assign lvl_v       = VAL_W'(lvl_q);
  assign alloc_mark  = ~want_v;             // -(order + 1)
  assign free_mark_v = ~VAL_W'(hlvl_q);

  // best-fit pick between the two children
  always_comb begin
    if (rda_q < want_v) begin
      go_right = 1'b1;
    end else if (rdb_q < want_v) begin
      go_right = 1'b0;
    end else begin
      go_right = !(rda_q <= rdb_q);
    end
  end

  assign child_l = {n_q[NODE_W-2:0], 1'b1};
  assign child   = go_right ? child_l + NODE_W'(1) : child_l;
  assign next_l  = {child[NODE_W-2:0], 1'b1};
  assign next_r  = next_l + NODE_W'(1);
  assign par_u   = par_of(u_q);
  assign sib_n   = sib_of(n_q);
  assign sib_h   = sib_of(handle_q);
  assign sib_p   = sib_of(par_u);

  // merge: val_q is the node just written, rdb_q its buddy
  always_comb begin
    if (val_q == lvl_v && rdb_q == lvl_v) begin
      pv = lvl_v + VAL_W'(1);
    end else if (val_q < 0 && rdb_q < 0) begin
      pv = -VAL_W'(1);
    end else begin
      pv = (val_q > rdb_q) ? val_q : rdb_q;
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = VAL_W'(node_level(clr_q));
    end
    if (cmd_i.fetch) begin
      raddr_a = action_q ? handle_q : '0;
    end
    if (cmd_i.init_desc) begin
      raddr_a = NODE_W'(1);
      raddr_b = NODE_W'(2);
    end
    if (cmd_i.desc_step) begin
      raddr_a = next_l;
      raddr_b = next_r;
    end
    if (cmd_i.mark) begin
      we      = 1'b1;
      waddr   = n_q;
      wdata   = alloc_mark;
      raddr_b = sib_n;
    end
    if (cmd_i.free_mark) begin
      we      = 1'b1;
      waddr   = handle_q;
      wdata   = VAL_W'(hlvl_q);
      raddr_b = sib_h;
    end
    if (cmd_i.up_step) begin
      we      = 1'b1;
      waddr   = par_u;
      wdata   = pv;
      raddr_b = sib_p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rda_q <= mem[raddr_a];
    rdb_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + NODE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      bytes_q  <= request_bytes_i;
      handle_q <= node_handle_i;
    end
    if (cmd_i.fetch) begin
      want_q <= want_d;
      hlvl_q <= node_level(handle_q);
    end
    if (cmd_i.init_desc) begin
      n_q   <= '0;
      lvl_q <= LVL_W'(TREE_ORDER);
      off_q <= '0;
    end
    if (cmd_i.desc_step) begin
      n_q   <= child;
      lvl_q <= lvl_q - LVL_W'(1);
      if (go_right) begin
        off_q <= off_q | (OFF_W'(1) << (lvl_q - LVL_W'(1)));
      end
    end
    if (cmd_i.mark) begin
      val_q <= alloc_mark;
      u_q   <= n_q;
    end
    if (cmd_i.free_mark) begin
      val_q <= VAL_W'(hlvl_q);
      u_q   <= handle_q;
      lvl_q <= hlvl_q;
    end
    if (cmd_i.up_step) begin
      val_q <= pv;
      u_q   <= par_u;
      lvl_q <= lvl_q + LVL_W'(1);
    end
    if (cmd_i.load_res) begin
      res_status_q <= cmd_i.status;
      res_node_q   <= '0;
      res_off_q    <= '0;
      res_ord_q    <= '0;
      if (cmd_i.status == STS_OK) begin
        if (action_q) begin
          res_ord_q <= hlvl_q;
        end else begin
          res_node_q <= n_q;
          res_off_q  <= off_q;
          res_ord_q  <= want_q[LVL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    sts_o.clr_done    = (clr_q == NODE_W'(NODE_COUNT - 1));
    sts_o.is_free     = action_q;
    sts_o.zero_size   = (bytes_q == '0);
    sts_o.no_fit      = (want_q > WANT_W'(TREE_ORDER)) || (rda_q < want_v);
    sts_o.want_top    = (want_q == WANT_W'(TREE_ORDER));
    sts_o.desc_last   = (WANT_W'(lvl_q - LVL_W'(1)) == want_q);
    sts_o.bad_free    = (handle_q == NODE_W'(NODE_COUNT)) || (rda_q != free_mark_v);
    sts_o.handle_root = (handle_q == '0);
    sts_o.at_root     = (n_q == '0);
    sts_o.up_last     = (u_q == NODE_W'(1)) || (u_q == NODE_W'(2));
  end

  assign status_o        = res_status_q;
  assign granted_node_o  = res_node_q;
  assign block_offset_o  = res_off_q;
  assign granted_order_o = res_ord_q;

endmodule

FILE: hw/rtl/bta_ctrl.sv
// Controller: sequences clearing, descent, marking, merge walk and response.
module bta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  bta_pkg::sts_t sts_i,
  output bta_pkg::cmd_t cmd_o
);
  import bta_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DESC  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_UP    = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state_q, state_d;
  status_e    st_q, st_d;
  logic       vld_q, vld_d;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    vld_d      = vld_q & ~rsp_ready_i;
    cmd_o      = '0;
    cmd_o.status = st_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_free) begin
          if (sts_i.bad_free) begin
            st_d    = STS_NOT_ALLOC;
            state_d = S_RESP;
          end else begin
            cmd_o.free_mark = 1'b1;
            st_d            = STS_OK;
            state_d         = sts_i.handle_root ? S_RESP : S_UP;
          end
        end else if (sts_i.zero_size) begin
          st_d    = STS_ZERO;
          state_d = S_RESP;
        end else if (sts_i.no_fit) begin
          st_d    = STS_NO_FIT;
          state_d = S_RESP;
        end else begin
          cmd_o.init_desc = 1'b1;
          state_d         = sts_i.want_top ? S_MARK : S_DESC;
        end
      end
      S_DESC: begin
        cmd_o.desc_step = 1'b1;
        if (sts_i.desc_last) begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        st_d       = STS_OK;
        state_d    = sts_i.at_root ? S_RESP : S_UP;
      end
      S_UP: begin
        cmd_o.up_step = 1'b1;
        if (sts_i.up_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        // wait for the output word slot to free up
        if (!vld_q || rsp_ready_i) begin
          cmd_o.load_res = 1'b1;
          vld_d          = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= STS_OK;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      vld_q   <= vld_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = vld_q;

endmodule

FILE: hw/rtl/buddy_tree_allocator.sv
// Top level of the binary buddy allocator over a heap-ordered tree.
//
//   channel | dir | word fields
//   req_i   | in  | action, request_bytes, node_handle
//   rsp_o   | out | status, granted_node, block_offset, granted_order
//
// One request at a time. An allocate walks from acceptance to the response word
// with one memory read per level going down and one read-modify-write per level
// going back up.
// After reset the node memory is swept one entry a cycle, all 2^(TREE_ORDER+1) - 1
// entries (2047), before the first request is taken.
// The response sits in an output register, so a stalled rsp_o only blocks the
// next request once that request has its own response ready.
module buddy_tree_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  bta_req_if.sink   req_i,
  bta_rsp_if.source rsp_o
);
  import bta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bta_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (req_i.action),
    .request_bytes_i (req_i.request_bytes),
    .node_handle_i   (req_i.node_handle),
    .status_o        (rsp_o.status),
    .granted_node_o  (rsp_o.granted_node),
    .block_offset_o  (rsp_o.block_offset),
    .granted_order_o (rsp_o.granted_order)
  );

  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> cmd.fetch)
    else $error("accepted request not followed by fetch");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_res |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten while pending");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.init_desc, cmd.desc_step, cmd.mark,
              cmd.free_mark, cmd.up_step, cmd.load_res}))
    else $error("conflicting datapath commands");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !req_i.ready)
    else $error("request accepted during memory sweep");

endmodule

FILE: test/buddy_tree_allocator_tb.sv
// Self-checking testbench for the buddy tree allocator: directed table, then random traffic.
module buddy_tree_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef logic signed [VAL_W-1:0] free_ord_t;

  typedef struct packed {
    status_e           status;
    logic [NODE_W-1:0] node;
    logic [OFF_W-1:0]  offset;
    logic [LVL_W-1:0]  order;
  } grant_t;

  typedef struct packed {
    logic              act;
    logic [REQ_W-1:0]  bytes;
    logic [NODE_W-1:0] handle;
    logic              typed;
    grant_t            given;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 21;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ACT_ALLOC, 20'd0,       11'd0,    1'b1, '{STS_ZERO,      11'd0,    10'd0, 4'd0}},
    '{ACT_ALLOC, 20'hFFFFF,   11'd2047, 1'b1, '{STS_NO_FIT,    11'd0,    10'd0, 4'd0}},
    '{ACT_ALLOC, 20'd65537,   11'd0,    1'b1, '{STS_NO_FIT,    11'd0,    10'd0, 4'd0}},
    '{ACT_FREE,  20'hFFFFF,   11'd2047, 1'b1, '{STS_NOT_ALLOC, 11'd0,    10'd0, 4'd0}},
    '{ACT_FREE,  20'd0,       11'd0,    1'b1, '{STS_NOT_ALLOC, 11'd0,    10'd0, 4'd0}},
    '{ACT_FREE,  20'd0,       11'd2046, 1'b1, '{STS_NOT_ALLOC, 11'd0,    10'd0, 4'd0}},
    '{ACT_ALLOC, 20'd65536,   11'd0,    1'b1, '{STS_OK,        11'd0,    10'd0, 4'd10}},
    '{ACT_ALLOC, 20'd1,       11'd0,    1'b1, '{STS_NO_FIT,    11'd0,    10'd0, 4'd0}},
    '{ACT_FREE,  20'd0,       11'd0,    1'b1, '{STS_OK,        11'd0,    10'd0, 4'd10}},
    '{ACT_ALLOC, 20'd1,       11'd2047, 1'b1, '{STS_OK,        11'd1023, 10'd0, 4'd0}},
    '{ACT_ALLOC, 20'd64,      11'd0,    1'b0, '0},
    '{ACT_ALLOC, 20'd65,      11'd0,    1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd511,  1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd1024, 1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd1024, 1'b0, '0},
    '{ACT_ALLOC, 20'd32768,   11'd0,    1'b0, '0},
    '{ACT_ALLOC, 20'd1024,    11'd0,    1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd3,    1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd1,    1'b0, '0},
    '{ACT_FREE,  20'd0,       11'd1023, 1'b0, '0},
    '{ACT_ALLOC, 20'd65536,   11'd0,    1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bta_req_if req_if ();
  bta_rsp_if rsp_if ();

  buddy_tree_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  free_ord_t   free_ord [NODE_COUNT];
  grant_t      grant_q [$];
  int unsigned live_nodes [$];
  int unsigned err_cnt = 0;
  int unsigned send_idle = 15;
  int unsigned recv_idle = 73;
  logic        hold_rsp = 1'b0;

  function automatic int unsigned node_depth(int unsigned n);
    int unsigned v;
    int unsigned d;
    v = n + 1;
    d = 0;
    while (v > 1) begin
      v >>= 1;
      d++;
    end
    return d;
  endfunction

  function automatic void clear_tree();
    for (int unsigned i = 0; i < NODE_COUNT; i++) begin
      free_ord[i] = free_ord_t'(TREE_ORDER - node_depth(i));
    end
  endfunction

  // recompute ancestors of n; lvl is the level of n
  function automatic void merge_up(int unsigned n, int lvl);
    int unsigned sib;
    int unsigned par;
    int          a;
    int          b;
    int          v;
    while (n != 0) begin
      sib = n[0] ? n + 1 : n - 1;
      par = (n - 1) >> 1;
      a = free_ord[n];
      b = free_ord[sib];
      if (a == lvl && b == lvl) begin
        v = lvl + 1;
      end else if (a < 0 && b < 0) begin
        v = -1;
      end else begin
        v = (a > b) ? a : b;
      end
      free_ord[par] = free_ord_t'(v);
      n = par;
      lvl++;
    end
  endfunction

  function automatic grant_t predict_grant(logic act, logic [REQ_W-1:0] bytes,
                                           logic [NODE_W-1:0] handle);
    grant_t      g;
    int unsigned s;
    int unsigned n;
    int unsigned d;
    int          want;
    int          lvl;
    int          lv;
    int          rv;
    g = '0;
    g.status = STS_OK;
    if (act == ACT_ALLOC) begin
      if (bytes == '0) begin
        g.status = STS_ZERO;
      end else begin
        s = (int'(bytes) - 1) >> BLOCK_SHIFT;
        want = 0;
        while (s > 0) begin
          s >>= 1;
          want++;
        end
        if (want > int'(TREE_ORDER) || int'(free_ord[0]) < want) begin
          g.status = STS_NO_FIT;
        end else begin
          // best fit: smaller fitting order wins, left on a tie
          n = 0;
          lvl = TREE_ORDER;
          while (lvl > want) begin
            lv = free_ord[2 * n + 1];
            rv = free_ord[2 * n + 2];
            if (lv < want) begin
              n = 2 * n + 2;
            end else if (rv < want) begin
              n = 2 * n + 1;
            end else begin
              n = (lv <= rv) ? 2 * n + 1 : 2 * n + 2;
            end
            lvl--;
          end
          free_ord[n] = free_ord_t'(-want - 1);
          merge_up(n, want);
          d = node_depth(n);
          g.node   = NODE_W'(n);
          g.offset = OFF_W'((n - ((1 << d) - 1)) << (TREE_ORDER - d));
          g.order  = LVL_W'(want);
        end
      end
    end else begin
      if (handle >= NODE_COUNT) begin
        g.status = STS_NOT_ALLOC;
      end else begin
        lvl = int'(TREE_ORDER) - int'(node_depth(handle));
        if (free_ord[handle] != free_ord_t'(-lvl - 1)) begin
          g.status = STS_NOT_ALLOC;
        end else begin
          free_ord[handle] = free_ord_t'(lvl);
          merge_up(handle, lvl);
          g.order = LVL_W'(lvl);
        end
      end
    end
    return g;
  endfunction

  // offer one word, wait for acceptance, then record the expected grant
  task automatic send_word(input logic act, input logic [REQ_W-1:0] bytes,
                           input logic [NODE_W-1:0] handle, input logic typed,
                           input grant_t given);
    grant_t g;
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.request_bytes <= bytes;
    req_if.node_handle   <= handle;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    g = predict_grant(act, bytes, handle);
    grant_q.push_back(typed ? given : g);
    if (g.status == STS_OK) begin
      if (act == ACT_ALLOC) begin
        live_nodes.push_back(g.node);
      end else begin
        for (int i = 0; i < live_nodes.size(); i++) begin
          if (live_nodes[i] == handle) begin
            live_nodes.delete(i);
            break;
          end
        end
      end
    end
  endtask

  task automatic send_random();
    logic [REQ_W-1:0]  bytes;
    logic [NODE_W-1:0] handle;
    int unsigned       r;
    int unsigned       k;
    bytes  = REQ_W'($urandom());
    handle = NODE_W'($urandom());
    r = $urandom_range(99);
    if (r < 45 || (r < 85 && live_nodes.size() == 0)) begin
      k = $urandom_range(99);
      if (k < 70) begin
        bytes = REQ_W'($urandom_range(512, 1));
      end else if (k < 92) begin
        bytes = REQ_W'($urandom_range(8192, 1));
      end else begin
        bytes = REQ_W'($urandom_range(65536, 1));
      end
      send_word(ACT_ALLOC, bytes, handle, 1'b0, '0);
    end else if (r < 85) begin
      handle = NODE_W'(live_nodes[$urandom_range(live_nodes.size() - 1)]);
      send_word(ACT_FREE, bytes, handle, 1'b0, '0);
    end else begin
      // noise: oversize, zero size, stray handles
      case ($urandom_range(3))
        0: send_word(ACT_ALLOC, bytes, handle, 1'b0, '0);
        1: send_word(ACT_ALLOC, '0, handle, 1'b0, '0);
        default: send_word(ACT_FREE, bytes, handle, 1'b0, '0);
      endcase
    end
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (grant_q.size() != 0);
  endtask

  function automatic void note_mismatch(string field, int unsigned want_v, int unsigned got_v);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch %s: expected %0d, got %0d", field, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin : rsp_check
    grant_t g;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected word: status %0d node %0d", rsp_if.status,
                   rsp_if.granted_node);
        end
      end else begin
        g = grant_q.pop_front();
        if (rsp_if.status !== g.status)
          note_mismatch("status", g.status, rsp_if.status);
        if (rsp_if.granted_node !== g.node)
          note_mismatch("granted_node", g.node, rsp_if.granted_node);
        if (rsp_if.block_offset !== g.offset)
          note_mismatch("block_offset", g.offset, rsp_if.block_offset);
        if (rsp_if.granted_order !== g.order)
          note_mismatch("granted_order", g.order, rsp_if.granted_order);
      end
    end
    rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ALLOC;
    req_if.request_bytes = '0;
    req_if.node_handle   = '0;
    rsp_if.ready         = 1'b0;
    clear_tree();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TAB[i].act, DIR_TAB[i].bytes, DIR_TAB[i].handle, DIR_TAB[i].typed,
                DIR_TAB[i].given);
    end
    repeat (150) send_random();

    // receiver holds off while words keep coming, so the block backs up
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp <= 1'b0;
      end
      repeat (20) send_random();
    join
    wait_drain();

    send_idle <= 73;
    recv_idle <= 15;
    repeat (170) send_random();
    wait_drain();

    send_idle <= 0;
    recv_idle <= 0;
    repeat (150) send_random();
    while (live_nodes.size() != 0) begin
      send_word(ACT_FREE, REQ_W'($urandom()), NODE_W'(live_nodes[0]), 1'b0, '0);
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    err_cnt += grant_q.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
